// ===== src/chbw_pkg.sv =====
package chbw_pkg;

   // Largest bitmap the block is built for, in chunks.
   localparam int MAX_CHUNKS_DEFAULT = 2048;

   // Fixed field widths.
   localparam int CHUNK_W = 12;
   localparam int LOAD_W = 9;
   localparam int RUNS_W = 11;
   localparam int LEN_W = 9;
   localparam int RANGE_COUNT_W = 16;
   localparam int BYTES_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register offsets on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_CHUNK_COUNT = 3'd0;

   // Depth of the result queue.
   localparam int RSP_DEPTH = 4;

   typedef enum logic [1:0] {
      ENC_ALL_PRESENT = 2'd0,
      ENC_ALL_ABSENT  = 2'd1,
      ENC_RANGES      = 2'd2,
      ENC_RAW         = 2'd3
   } enc_type;

   typedef enum logic {
      KIND_HEADER = 1'b0,
      KIND_BODY   = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_ACC,
      ST_DECIDE,
      ST_HDR,
      ST_RNG_CNT,
      ST_RNG_RD,
      ST_RNG_WALK,
      ST_RNG_END,
      ST_RAW_RD,
      ST_RAW_ACC,
      ST_DONE
   } engine_state_type;

   // A finished bitmap handed from the front to the engine.
   typedef struct packed {
      logic               valid;
      logic [CHUNK_W-1:0] n;
      logic [LOAD_W-1:0]  loaded;
   } job_type;

   // Store write from the front.
   typedef struct packed {
      logic              en;
      logic [LOAD_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   // One result item.
   typedef struct packed {
      kind_type           item_kind;
      enc_type            encoding;
      logic [CHUNK_W-1:0] received_total;
      logic [LEN_W-1:0]   body_length;
      logic [63:0]        word_data;
      logic [BYTES_W-1:0] word_bytes;
      logic               final_item;
   } rsp_item_type;

endpackage

// ===== src/chbw_front.sv =====
module chbw_front #(
   parameter int MAX_CHUNKS = chbw_pkg::MAX_CHUNKS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [7:0]                         req_byte_value,
   input  logic                               req_last_byte,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [chbw_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [chbw_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [chbw_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output chbw_pkg::job_type                  job,
   input  logic                               job_done,
   output chbw_pkg::store_wr_type             store_wr
);
   import chbw_pkg::*;

   localparam int STORE_BYTES = (MAX_CHUNKS + 7) / 8;

   logic [CHUNK_W-1:0] chunk_count_ff, chunk_count_in;
   logic [LOAD_W-1:0]  loaded_ff, loaded_in;
   job_type            job_ff, job_in;
   logic               accept;
   logic               room;
   logic [CHUNK_W-1:0] n_clamped;

   assign pready = 1'b1;
   assign prdata = CSR_DATA_W'(chunk_count_ff);
   assign full = job_ff.valid;
   assign accept = push && !job_ff.valid;
   assign room = loaded_ff < LOAD_W'(STORE_BYTES);
   assign n_clamped = (chunk_count_ff > CHUNK_W'(MAX_CHUNKS)) ?
                      CHUNK_W'(MAX_CHUNKS) : chunk_count_ff;

   // Configuration register write.
   always_comb begin
      chunk_count_in = chunk_count_ff;
      if (psel && penable && pwrite && paddr == CSR_CHUNK_COUNT) begin
         chunk_count_in = pwdata[CHUNK_W-1:0];
      end
   end

   // Byte store write; bytes past the store are dropped.
   always_comb begin
      store_wr.en = accept && room;
      store_wr.addr = loaded_ff;
      store_wr.data = req_byte_value;
   end

   // Load count and hand-off of the finished bitmap.
   always_comb begin
      loaded_in = loaded_ff;
      job_in = job_ff;
      if (job_done) begin
         job_in.valid = 1'b0;
      end
      if (accept) begin
         if (room) begin
            loaded_in = loaded_ff + LOAD_W'(1);
         end
         if (req_last_byte) begin
            job_in.valid = 1'b1;
            job_in.n = n_clamped;
            job_in.loaded = room ? loaded_ff + LOAD_W'(1) : loaded_ff;
            loaded_in = '0;
         end
      end
   end

   assign job = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_count_ff <= '0;
         loaded_ff <= '0;
         job_ff <= '0;
      end else begin
         chunk_count_ff <= chunk_count_in;
         loaded_ff <= loaded_in;
         job_ff <= job_in;
      end
   end

endmodule

// ===== src/chbw_engine.sv =====
module chbw_engine #(
   parameter int MAX_CHUNKS = chbw_pkg::MAX_CHUNKS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  chbw_pkg::store_wr_type store_wr,
   input  chbw_pkg::job_type      job,
   output logic                   job_done,
   output logic                   item_push,
   output chbw_pkg::rsp_item_type item,
   input  logic                   item_full
);
   import chbw_pkg::*;

   localparam int STORE_BYTES = (MAX_CHUNKS + 7) / 8;
   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   // Bitmap store.
   logic [7:0] store_mem [0:STORE_BYTES-1];
   logic [7:0] rdata_ff;

   engine_state_type   state_ff, state_in;
   logic [LOAD_W-1:0]  idx_ff, idx_in;
   logic [2:0]         pos_ff, pos_in;
   logic               in_run_ff, in_run_in;
   logic [CHUNK_W-1:0] start_ff, start_in;
   logic [CHUNK_W-1:0] present_ff, present_in;
   logic [RUNS_W-1:0]  runs_ff, runs_in;
   logic               prev_ff, prev_in;
   enc_type            enc_ff, enc_in;
   logic [LEN_W-1:0]   body_len_ff, body_len_in;
   logic [RUNS_W-1:0]  rng_cnt_ff, rng_cnt_in;
   logic [63:0]        word_ff, word_in;
   logic [2:0]         lane_ff, lane_in;
   logic [CHUNK_W-1:0] n_ff, n_in;
   logic [LOAD_W-1:0]  loaded_ff, loaded_in;
   logic [LOAD_W-1:0]  nbytes_ff, nbytes_in;

   logic [CHUNK_W-1:0] rem;
   logic [7:0]         in_mask;
   logic [7:0]         data_m;
   logic [7:0]         abs_v;
   logic [7:0]         starts;
   logic [7:0]         cand;
   logic               found;
   logic [2:0]         hit;
   logic [CHUNK_W-1:0] bit_pos;
   logic               last_idx;
   logic [14:0]        range_len;
   logic [63:0]        raw_word;
   logic               raw_flush;
   logic [LOAD_W-1:0]  job_nbytes;

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr[ADDR_W-1:0]] <= store_wr.data;
      end
      rdata_ff <= store_mem[idx_ff[ADDR_W-1:0]];
   end

   // Current byte, cleared where it was never loaded and masked to the chunk count.
   assign rem = n_ff - {idx_ff, 3'b000};
   assign in_mask = (rem >= CHUNK_W'(8)) ? 8'hFF : 8'((9'd1 << rem[2:0]) - 9'd1);
   assign data_m = ((idx_ff < loaded_ff) ? rdata_ff : 8'h00) & in_mask;
   assign abs_v = ~data_m & in_mask;
   assign starts = abs_v & ~{abs_v[6:0], prev_ff};
   assign last_idx = (idx_ff + LOAD_W'(1)) == nbytes_ff;
   assign job_nbytes = LOAD_W'((13'(job.n) + 13'd7) >> 3);

   // Next boundary in the current byte at or above the bit cursor.
   assign cand = (in_run_ff ? ~abs_v : abs_v) & (8'hFF << pos_ff);
   always_comb begin
      found = 1'b0;
      hit = '0;
      for (int j = 7; j >= 0; j--) begin
         if (cand[j]) begin
            found = 1'b1;
            hit = 3'(j);
         end
      end
   end
   assign bit_pos = {idx_ff, hit};

   assign range_len = 15'd8 + 15'({runs_ff, 3'b000});
   assign raw_word = ((lane_ff == 3'd0) ? 64'd0 : word_ff) |
                     (64'(data_m) << {lane_ff, 3'b000});
   assign raw_flush = (lane_ff == 3'd7) || last_idx;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job.valid) begin
               state_in = (job_nbytes == '0) ? ST_DECIDE : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_ACC;
         ST_SCAN_ACC: state_in = last_idx ? ST_DECIDE : ST_SCAN_RD;
         ST_DECIDE: state_in = ST_HDR;
         ST_HDR: begin
            if (!item_full) begin
               unique case (enc_ff)
                  ENC_RANGES: state_in = ST_RNG_CNT;
                  ENC_RAW: state_in = ST_RAW_RD;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RNG_CNT: if (!item_full) state_in = ST_RNG_RD;
         ST_RNG_RD: state_in = ST_RNG_WALK;
         ST_RNG_WALK: begin
            if (!found) begin
               state_in = last_idx ? ST_RNG_END : ST_RNG_RD;
            end
         end
         ST_RNG_END: if (!in_run_ff || !item_full) state_in = ST_DONE;
         ST_RAW_RD: state_in = ST_RAW_ACC;
         ST_RAW_ACC: begin
            if (!raw_flush) begin
               state_in = ST_RAW_RD;
            end else if (!item_full) begin
               state_in = last_idx ? ST_DONE : ST_RAW_RD;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath registers.
   always_comb begin
      idx_in = idx_ff;
      pos_in = pos_ff;
      in_run_in = in_run_ff;
      start_in = start_ff;
      present_in = present_ff;
      runs_in = runs_ff;
      prev_in = prev_ff;
      enc_in = enc_ff;
      body_len_in = body_len_ff;
      rng_cnt_in = rng_cnt_ff;
      word_in = word_ff;
      lane_in = lane_ff;
      n_in = n_ff;
      loaded_in = loaded_ff;
      nbytes_in = nbytes_ff;
      job_done = 1'b0;
      item_push = 1'b0;
      item.item_kind = KIND_BODY;
      item.encoding = enc_ff;
      item.received_total = present_ff;
      item.body_length = body_len_ff;
      item.word_data = 64'd0;
      item.word_bytes = BYTES_W'(8);
      item.final_item = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            n_in = job.n;
            loaded_in = job.loaded;
            nbytes_in = job_nbytes;
            idx_in = '0;
            present_in = '0;
            runs_in = '0;
            prev_in = 1'b0;
         end
         ST_SCAN_ACC: begin
            present_in = present_ff + CHUNK_W'($countones(data_m));
            runs_in = runs_ff + RUNS_W'($countones(starts));
            prev_in = abs_v[7];
            idx_in = idx_ff + LOAD_W'(1);
         end
         ST_DECIDE: begin
            body_len_in = '0;
            if (present_ff == n_ff) begin
               enc_in = ENC_ALL_PRESENT;
            end else if (present_ff == '0) begin
               enc_in = ENC_ALL_ABSENT;
            end else if (range_len < 15'(nbytes_ff)) begin
               enc_in = ENC_RANGES;
               body_len_in = LEN_W'(range_len);
            end else begin
               enc_in = ENC_RAW;
               body_len_in = LEN_W'(nbytes_ff);
            end
         end
         ST_HDR: begin
            item_push = !item_full;
            item.item_kind = KIND_HEADER;
            item.word_bytes = '0;
            item.final_item = (enc_ff == ENC_ALL_PRESENT) || (enc_ff == ENC_ALL_ABSENT);
            idx_in = '0;
            lane_in = '0;
            pos_in = '0;
            in_run_in = 1'b0;
            rng_cnt_in = '0;
         end
         ST_RNG_CNT: begin
            item_push = !item_full;
            item.word_data = 64'(RANGE_COUNT_W'(runs_ff));
         end
         ST_RNG_WALK: begin
            if (found) begin
               if (in_run_ff) begin
                  item.word_data = {32'(bit_pos - start_ff), 32'(start_ff)};
                  item.final_item = (rng_cnt_ff + RUNS_W'(1)) == runs_ff;
                  if (!item_full) begin
                     item_push = 1'b1;
                     rng_cnt_in = rng_cnt_ff + RUNS_W'(1);
                     in_run_in = 1'b0;
                     pos_in = hit;
                  end
               end else begin
                  start_in = bit_pos;
                  in_run_in = 1'b1;
                  pos_in = hit;
               end
            end else if (!last_idx) begin
               idx_in = idx_ff + LOAD_W'(1);
               pos_in = '0;
            end
         end
         ST_RNG_END: begin
            item.word_data = {32'(n_ff - start_ff), 32'(start_ff)};
            item.final_item = 1'b1;
            item_push = in_run_ff && !item_full;
         end
         ST_RAW_ACC: begin
            item.word_data = raw_word;
            item.word_bytes = BYTES_W'(lane_ff) + BYTES_W'(1);
            item.final_item = last_idx;
            if (!raw_flush) begin
               word_in = raw_word;
               lane_in = lane_ff + 3'd1;
               idx_in = idx_ff + LOAD_W'(1);
            end else if (!item_full) begin
               item_push = 1'b1;
               lane_in = '0;
               idx_in = idx_ff + LOAD_W'(1);
            end
         end
         ST_DONE: job_done = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      in_run_ff <= in_run_in;
      start_ff <= start_in;
      present_ff <= present_in;
      runs_ff <= runs_in;
      prev_ff <= prev_in;
      enc_ff <= enc_in;
      body_len_ff <= body_len_in;
      rng_cnt_ff <= rng_cnt_in;
      word_ff <= word_in;
      lane_ff <= lane_in;
      n_ff <= n_in;
      loaded_ff <= loaded_in;
      nbytes_ff <= nbytes_in;
   end

endmodule

// ===== src/chbw_rsp_fifo.sv =====
module chbw_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  chbw_pkg::rsp_item_type wr_item,
   output logic                   wr_full,
   input  logic                   pop,
   output logic                   empty,
   output chbw_pkg::rsp_item_type rd_item
);
   import chbw_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);

   rsp_item_type       slot_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign wr_full = count_ff == (PTR_W+1)'(RSP_DEPTH);
   assign empty = count_ff == '0;
   assign rd_item = slot_ff[rd_ptr_ff];
   assign do_wr = wr_en && !wr_full;
   assign do_rd = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + (PTR_W+1)'(do_wr) - (PTR_W+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ===== src/chunk_bitmap_witness_encoder_core.sv =====
// Chunk bitmap witness encoder.
// Requests carry one bitmap byte each (bit k of byte b is chunk 8*b+k) and
// are taken on push while full is low. The byte flagged req_last_byte closes
// the bitmap; full then stays high until its results have all been queued.
// The register chunk_count sits at address 0 of the APB-style port.
// Results come out of a four-deep queue: the oldest is on the rsp_ ports while
// empty is low and leaves on pop. Each bitmap yields one header and then up to
// 32 body words, the last flagged by rsp_final_item.
// Bytes load at one per cycle while full is low. After the last byte the
// engine scans the stored bitmap, each byte by a registered store read and
// then an accumulate step, then decides the encoding and sends the header.
// The raw body reads and accumulates each byte the same way; the range body
// reads each byte and then walks its run edges one at a time.
// A stalled receiver fills the result queue and the engine waits on it.
// Reset empties the queues, clears chunk_count and the load count; the byte
// store itself is not cleared, since bytes past the load count are taken as zero.
module chunk_bitmap_witness_encoder_core #(
   parameter int MAX_CHUNKS = chbw_pkg::MAX_CHUNKS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [7:0]                      req_byte_value,
   input  logic                            req_last_byte,
   output logic                            empty,
   input  logic                            pop,
   output logic                            rsp_item_kind,
   output logic [1:0]                      rsp_encoding,
   output logic [11:0]                     rsp_received_total,
   output logic [8:0]                      rsp_body_length,
   output logic [63:0]                     rsp_word_data,
   output logic [3:0]                      rsp_word_bytes,
   output logic                            rsp_final_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [chbw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [chbw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [chbw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import chbw_pkg::*;

   job_type      job;
   store_wr_type store_wr;
   logic         job_done;
   logic         item_push;
   logic         item_full;
   rsp_item_type item;
   rsp_item_type head;

   chbw_front #(.MAX_CHUNKS(MAX_CHUNKS)) u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_byte_value(req_byte_value),
      .req_last_byte(req_last_byte),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .job(job),
      .job_done(job_done),
      .store_wr(store_wr)
   );

   chbw_engine #(.MAX_CHUNKS(MAX_CHUNKS)) u_engine (
      .clock(clock),
      .reset(reset),
      .store_wr(store_wr),
      .job(job),
      .job_done(job_done),
      .item_push(item_push),
      .item(item),
      .item_full(item_full)
   );

   chbw_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .wr_en(item_push),
      .wr_item(item),
      .wr_full(item_full),
      .pop(pop),
      .empty(empty),
      .rd_item(head)
   );

   // Result fields.
   assign rsp_item_kind = head.item_kind;
   assign rsp_encoding = head.encoding;
   assign rsp_received_total = head.received_total;
   assign rsp_body_length = head.body_length;
   assign rsp_word_data = head.word_data;
   assign rsp_word_bytes = head.word_bytes;
   assign rsp_final_item = head.final_item;

endmodule
